[src/ppid_pkg.sv]
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants for the position PID with feedforward:
// register map, register reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ppid_pkg;

    // Fixed register widths
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_KFF  = 3'd3,
        REG_ILIM = 3'd4,
        REG_OLIM = 3'd5,
        REG_BAND = 3'd6
    } cfg_reg_t;

    // Reset values
    localparam logic signed [GAIN_W-1:0] KP_RST   = 16'sd3072;
    localparam logic signed [GAIN_W-1:0] KI_RST   = 16'sd97;
    localparam logic signed [GAIN_W-1:0] KD_RST   = 16'sd845;
    localparam logic signed [GAIN_W-1:0] KFF_RST  = 16'sd0;
    localparam logic [LIMIT_W-1:0]       ILIM_RST = 15'd50;
    localparam logic [LIMIT_W-1:0]       OLIM_RST = 15'd600;
    localparam logic [LIMIT_W-1:0]       BAND_RST = 15'd30;

    // Configuration bundle seen by the datapath
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [GAIN_W-1:0] kff;
        logic [LIMIT_W-1:0]       ilim;
        logic [LIMIT_W-1:0]       olim;
        logic [LIMIT_W-1:0]       band;
    } cfg_t;

endpackage

`default_nettype wire

[src/ppid_cfg.sv]
// ----------------------------------------------------------------------------
// ppid_cfg
// Configuration register file: gains, limits and integral reset band.
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_cfg
    import ppid_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    // Register writes; unmapped indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp   <= KP_RST;
            cfg_reg.ki   <= KI_RST;
            cfg_reg.kd   <= KD_RST;
            cfg_reg.kff  <= KFF_RST;
            cfg_reg.ilim <= ILIM_RST;
            cfg_reg.olim <= OLIM_RST;
            cfg_reg.band <= BAND_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP:   cfg_reg.kp   <= cfg_wdata[GAIN_W-1:0];
                REG_KI:   cfg_reg.ki   <= cfg_wdata[GAIN_W-1:0];
                REG_KD:   cfg_reg.kd   <= cfg_wdata[GAIN_W-1:0];
                REG_KFF:  cfg_reg.kff  <= cfg_wdata[GAIN_W-1:0];
                REG_ILIM: cfg_reg.ilim <= cfg_wdata[LIMIT_W-1:0];
                REG_OLIM: cfg_reg.olim <= cfg_wdata[LIMIT_W-1:0];
                REG_BAND: cfg_reg.band <= cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/ppid_state.sv]
// ----------------------------------------------------------------------------
// ppid_state
// Controller state update on each accepted sample: integral sum with reset
// band and clamp, previous error, and the error delta. Feeds stage 1.
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_state
    import ppid_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire logic                          in_valid,
    input  wire logic signed [DATA_WIDTH-1:0]  in_error,
    input  wire cfg_t                          cfg,
    output logic                               st_valid,
    output logic signed [DATA_WIDTH-1:0]       st_error,
    output logic signed [DATA_WIDTH:0]         st_delta,
    output logic signed [DATA_WIDTH-1:0]       st_sum
);

    // Compare width: holds error + sum, magnitudes and 15-bit limits
    localparam int CW = (DATA_WIDTH + 2 > LIMIT_W + 2) ? DATA_WIDTH + 2 : LIMIT_W + 2;
    localparam logic signed [CW-1:0] DMAX = {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};

    logic signed [DATA_WIDTH-1:0] prev_reg;
    logic signed [DATA_WIDTH-1:0] sum_reg;
    logic signed [DATA_WIDTH-1:0] sum_next;
    logic signed [DATA_WIDTH:0]   delta_next;

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] error_reg;
    logic signed [DATA_WIDTH:0]   delta_reg;
    logic signed [DATA_WIDTH-1:0] sum1_reg;

    logic signed [CW-1:0] e_ext;
    logic signed [CW-1:0] sum_ext;
    logic signed [CW-1:0] prev_ext;
    logic signed [CW-1:0] mag;
    logic signed [CW-1:0] band_ext;
    logic signed [CW-1:0] ilim_ext;
    logic signed [CW-1:0] acc;
    logic signed [CW-1:0] diff;
    logic                 accept;

    assign accept   = advance && in_valid;
    assign e_ext    = {{(CW-DATA_WIDTH){in_error[DATA_WIDTH-1]}}, in_error};
    assign sum_ext  = {{(CW-DATA_WIDTH){sum_reg[DATA_WIDTH-1]}}, sum_reg};
    assign prev_ext = {{(CW-DATA_WIDTH){prev_reg[DATA_WIDTH-1]}}, prev_reg};
    assign band_ext = {{(CW-LIMIT_W){1'b0}}, cfg.band};
    assign ilim_ext = {{(CW-LIMIT_W){1'b0}}, cfg.ilim};
    assign mag      = e_ext[CW-1] ? -e_ext : e_ext;

    // Integral: accumulate, clear outside band, clamp to limit and data range
    always_comb begin
        acc = e_ext + sum_ext;
        if (mag > band_ext) begin
            acc = '0;
        end
        if (acc > ilim_ext) begin
            acc = ilim_ext;
        end else if (acc < -ilim_ext) begin
            acc = -ilim_ext;
        end
        if (acc > DMAX) begin
            acc = DMAX;
        end else if (acc < -DMAX) begin
            acc = -DMAX;
        end
        sum_next = acc[DATA_WIDTH-1:0];
    end

    // Error change against the previous sample
    assign diff       = e_ext - prev_ext;
    assign delta_next = diff[DATA_WIDTH:0];

    // Controller state, updated only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end else if (accept) begin
            prev_reg <= in_error;
            sum_reg  <= sum_next;
        end
    end

    // Stage 1 register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            error_reg <= in_error;
            delta_reg <= delta_next;
            sum1_reg  <= sum_next;
        end
    end

    assign st_valid = valid_reg;
    assign st_error = error_reg;
    assign st_delta = delta_reg;
    assign st_sum   = sum1_reg;

endmodule

`default_nettype wire

[src/ppid_datapath.sv]
// ----------------------------------------------------------------------------
// ppid_datapath
// Gain products, feedforward truncation, term sum, Q-format truncation
// toward zero and output clamp, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_datapath
    import ppid_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          advance,
    input  wire cfg_t                          cfg,
    input  wire logic                          in_valid,
    input  wire logic signed [DATA_WIDTH-1:0]  in_error,
    input  wire logic signed [DATA_WIDTH:0]    in_delta,
    input  wire logic signed [DATA_WIDTH-1:0]  in_sum,
    output logic                               out_valid,
    output logic [DATA_WIDTH-1:0]              out_drive
);

    localparam int PW = GAIN_W + DATA_WIDTH + 1;  // product width
    localparam int TW = PW + 2;                   // four-term sum width
    localparam logic signed [TW-1:0] DMAX = {{(TW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};

    // Stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] p_kp_reg;
    logic signed [PW-1:0] p_ki_reg;
    logic signed [PW-1:0] p_kd_reg;
    logic signed [PW-1:0] p_ff_reg;
    logic signed [PW-1:0] p_kp_next;
    logic signed [PW-1:0] p_ki_next;
    logic signed [PW-1:0] p_kd_next;
    logic signed [PW-1:0] p_ff_next;

    assign p_kp_next = $signed(cfg.kp)  * in_error;
    assign p_ki_next = $signed(cfg.ki)  * in_sum;
    assign p_kd_next = $signed(cfg.kd)  * in_delta;
    assign p_ff_next = $signed(cfg.kff) * in_delta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p_kp_reg <= p_kp_next;
            p_ki_reg <= p_ki_next;
            p_kd_reg <= p_kd_next;
            p_ff_reg <= p_ff_next;
        end
    end

    // Stage 3: feedforward truncated toward zero, then the term sum
    logic                 v3_reg;
    logic signed [TW-1:0] total_reg;
    logic signed [TW-1:0] total_next;
    logic signed [PW-1:0] ff_q;
    logic signed [PW-1:0] ff_scaled;

    always_comb begin
        ff_q = p_ff_reg >>> GAIN_FRAC_BITS;
        if (p_ff_reg[PW-1] && (p_ff_reg[GAIN_FRAC_BITS-1:0] != '0)) begin
            ff_q = ff_q + PW'(1);
        end
        ff_scaled = ff_q <<< GAIN_FRAC_BITS;
    end

    assign total_next = {{(TW-PW){ff_scaled[PW-1]}}, ff_scaled}
                      + {{(TW-PW){p_kp_reg[PW-1]}}, p_kp_reg}
                      + {{(TW-PW){p_kd_reg[PW-1]}}, p_kd_reg}
                      + {{(TW-PW){p_ki_reg[PW-1]}}, p_ki_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (advance) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            total_reg <= total_next;
        end
    end

    // Stage 4: truncate toward zero, clamp to output limit and data range
    logic                         v4_reg;
    logic [DATA_WIDTH-1:0]        drive_reg;
    logic [DATA_WIDTH-1:0]        drive_next;
    logic signed [TW-1:0]         q;
    logic signed [TW-1:0]         olim_ext;

    assign olim_ext = {{(TW-LIMIT_W){1'b0}}, cfg.olim};

    always_comb begin
        q = total_reg >>> GAIN_FRAC_BITS;
        if (total_reg[TW-1] && (total_reg[GAIN_FRAC_BITS-1:0] != '0)) begin
            q = q + TW'(1);
        end
        if (q > olim_ext) begin
            q = olim_ext;
        end else if (q < -olim_ext) begin
            q = -olim_ext;
        end
        if (q > DMAX) begin
            q = DMAX;
        end else if (q < -DMAX) begin
            q = -DMAX;
        end
        drive_next = q[DATA_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (advance) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_drive = drive_reg;

endmodule

`default_nettype wire

[src/position_pid_with_feedforward.sv]
// m_tvalid rises once an accepted input transaction has passed through the four pipeline registers.
// Throughput: one error sample per cycle while the output is not stalled, set by the four-register pipeline
// (state update, gain products, term sum, truncate and clamp).
// The pipeline advances whenever the output register is empty or taken.
// Reset (aresetn low, synchronous): registers return to their defaults,
// integral sum and previous error clear to zero, pipeline empties.
// ----------------------------------------------------------------------------
// position_pid_with_feedforward
// Position PID controller with feedforward on the error change, integral
// clamp and integral reset band; one drive value per error sample.
// ----------------------------------------------------------------------------
`default_nettype none

module position_pid_with_feedforward
    import ppid_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 8,
    localparam int TDATA_W       = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [TDATA_W-1:0]     s_tdata,   // [DATA_WIDTH-1:0] error
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [TDATA_W-1:0]          m_tdata,   // [DATA_WIDTH-1:0] drive
    // Configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int CW = (DATA_WIDTH + 2 > LIMIT_W + 2) ? DATA_WIDTH + 2 : LIMIT_W + 2;

    cfg_t                         cfg;
    logic                         advance;
    logic                         st_valid;
    logic signed [DATA_WIDTH-1:0] st_error;
    logic signed [DATA_WIDTH:0]   st_delta;
    logic signed [DATA_WIDTH-1:0] st_sum;
    logic [DATA_WIDTH-1:0]        drive;

    // Whole pipeline moves when the output register can take a value
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    ppid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ppid_state #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_valid (s_tvalid),
        .in_error (s_tdata[DATA_WIDTH-1:0]),
        .cfg      (cfg),
        .st_valid (st_valid),
        .st_error (st_error),
        .st_delta (st_delta),
        .st_sum   (st_sum)
    );

    ppid_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cfg       (cfg),
        .in_valid  (st_valid),
        .in_error  (st_error),
        .in_delta  (st_delta),
        .in_sum    (st_sum),
        .out_valid (m_tvalid),
        .out_drive (drive)
    );

    assign m_tdata = TDATA_W'(drive);

    // Checks
    logic signed [CW-1:0] drive_ext;
    logic signed [CW-1:0] olim_ext;

    assign drive_ext = {{(CW-DATA_WIDTH){drive[DATA_WIDTH-1]}}, drive};
    assign olim_ext  = {{(CW-LIMIT_W){1'b0}}, cfg.olim};

    // Every delivered drive lies inside the output limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((drive_ext <= olim_ext) && (drive_ext >= -olim_ext)))
        else $error("drive outside output limit");

    // A held result blocks new input transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // Reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
